// File: src/ipep_pkg.sv
// Shared types and constants for the IPv4 endpoint text parser.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package ipep_pkg;

   // Character codes that the parser recognizes.
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_NINE  = 8'h39;
   localparam logic [7:0] CH_DOT   = 8'h2E;
   localparam logic [7:0] CH_COLON = 8'h3A;
   localparam logic [7:0] CH_STAR  = 8'h2A;

   // The "unix:" prefix and the length at which a match rejects the string.
   localparam int UNIX_TAG_LEN    = 5;
   localparam int UNIX_REJECT_LEN = UNIX_TAG_LEN + 1;

   // Saturation points and limits of the parse state.
   localparam int CHAR_COUNT_MAX = 7;
   localparam int HOST_LEN_MAX   = 2;
   localparam int DOT_COUNT_MAX  = 7;
   localparam int DOT_COUNT_REQ  = 3;
   localparam int OCTET_MAX      = 255;
   localparam int OCTET_SAT      = 256;
   localparam int PORT_MAX       = 65535;
   localparam int PORT_SAT       = 65536;

   // Depth of the queue between front and back.
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

   typedef enum logic [3:0] {
      ERR_NONE           = 4'd0,
      ERR_EMPTY          = 4'd1,
      ERR_UNIX           = 4'd2,
      ERR_BAD_PORT       = 4'd3,
      ERR_NEED_HOST      = 4'd4,
      ERR_NO_PORT        = 4'd5,
      ERR_NO_HOST        = 4'd6,
      ERR_STAR_NO_LISTEN = 4'd7,
      ERR_BAD_IP         = 4'd8
   } ipep_err_type;

   // One classified beat as it travels from the front to the back.
   typedef struct packed {
      logic       end_req;
      logic       is_digit;
      logic [3:0] digit;
      logic       is_dot;
      logic       is_colon;
      logic       is_star;
      logic       tag_miss;
   } ipep_item_type;

   function automatic logic [7:0] unix_tag_char(input logic [2:0] pos);
      logic [7:0] c;
      case (pos)
         3'd0:    c = 8'h75;  // u
         3'd1:    c = 8'h6E;  // n
         3'd2:    c = 8'h69;  // i
         3'd3:    c = 8'h78;  // x
         3'd4:    c = 8'h3A;  // :
         default: c = 8'h00;
      endcase
      return c;
   endfunction

endpackage

`default_nettype wire

// File: src/ipep_front.sv
// Front end of the endpoint parser: accepts input beats and classifies each character.
// Depends on ipep_pkg; feeds ipep_queue.
`default_nettype none

module ipep_front
   import ipep_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_valid,
   input  wire logic [7:0]    req_ch,
   input  wire logic          req_end_req,
   input  wire logic          queue_full,
   output logic               req_stall,
   output logic               push,
   output ipep_item_type      push_item
);

   // Position within the string, saturating once past the prefix.
   logic [2:0] pos_ff;
   logic [2:0] pos_in;

   assign req_stall = queue_full;
   assign push      = req_valid && !queue_full;

   always_comb begin
      push_item          = '0;
      push_item.end_req  = req_end_req;
      push_item.is_digit = req_ch inside {[CH_ZERO:CH_NINE]};
      push_item.digit    = 4'(req_ch - CH_ZERO);
      push_item.is_dot   = (req_ch == CH_DOT);
      push_item.is_colon = (req_ch == CH_COLON);
      push_item.is_star  = (req_ch == CH_STAR);
      push_item.tag_miss = (pos_ff < 3'(UNIX_TAG_LEN)) && (req_ch != unix_tag_char(pos_ff));
   end

   always_comb begin
      pos_in = pos_ff;
      if (push) begin
         if (req_end_req) begin
            pos_in = '0;
         end else if (pos_ff < 3'(UNIX_TAG_LEN)) begin
            pos_in = pos_ff + 3'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= '0;
      end else begin
         pos_ff <= pos_in;
      end
   end

endmodule

`default_nettype wire

// File: src/ipep_queue.sv
// Short queue of classified beats between the front and the back of the parser.
// Depends on ipep_pkg for the item type and the depth.
`default_nettype none

module ipep_queue
   import ipep_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          push,
   input  wire ipep_item_type push_item,
   input  wire logic          pop,
   output logic               full,
   output logic               nonempty,
   output ipep_item_type      head_item
);

   ipep_item_type           slot_ff [QUEUE_DEPTH];
   logic [QUEUE_AW-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_AW-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_AW:0]       count_ff, count_in;

   assign full      = (count_ff == (QUEUE_AW+1)'(QUEUE_DEPTH));
   assign nonempty  = (count_ff != '0);
   assign head_item = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= (QUEUE_AW+1)'(QUEUE_DEPTH))
      else $error("queue count beyond depth");

   a_pop_drains: assert property (@(posedge clock) disable iff (reset)
      pop && !push |=> count_ff == $past(count_ff) - 1'b1)
      else $error("queue count did not drop on pop");

endmodule

`default_nettype wire

// File: src/ipep_back.sv
// Back end of the endpoint parser: holds the parse state, applies each classified
// beat and registers the result on a terminator. Depends on ipep_pkg.
`default_nettype none

module ipep_back
   import ipep_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          csr_write_enable,
   input  wire logic          csr_write_data,
   input  wire logic          queue_nonempty,
   input  wire ipep_item_type head_item,
   output logic               pop,
   output logic               rsp_valid,
   input  wire logic          rsp_stall,
   output logic               rsp_ok,
   output logic [3:0]         rsp_error_code,
   output logic [31:0]        rsp_ip_address,
   output logic [15:0]        rsp_port_number,
   output logic               rsp_wildcard_host
);

   logic        listen_mode_ff;
   logic [2:0]  char_count_ff,    char_count_in;
   logic        prefix_match_ff,  prefix_match_in;
   logic        seen_colon_ff,    seen_colon_in;
   logic [1:0]  host_length_ff,   host_length_in;
   logic        host_is_star_ff,  host_is_star_in;
   logic [8:0]  octet_value_ff,   octet_value_in;
   logic [2:0]  dot_count_ff,     dot_count_in;
   logic [31:0] address_accum_ff, address_accum_in;
   logic        host_bad_ff,      host_bad_in;
   logic [16:0] port_accum_ff,    port_accum_in;
   logic        port_bad_ff,      port_bad_in;
   logic        port_digits_ff,   port_digits_in;

   logic        rsp_valid_ff;
   logic        rsp_ok_ff;
   logic [3:0]  rsp_error_code_ff;
   logic [31:0] rsp_ip_address_ff;
   logic [15:0] rsp_port_number_ff;
   logic        rsp_wildcard_host_ff;

   logic        slot_free;
   logic        load_result;
   logic [11:0] octet_next;
   logic [19:0] port_next;
   logic [31:0] address_full;
   logic        port_ok;
   ipep_err_type err;
   logic [31:0] res_ip;
   logic [15:0] res_port;
   logic        res_wild;

   // Character beats never produce a result, so only a terminator waits for the output slot.
   assign slot_free   = !rsp_valid_ff || !rsp_stall;
   assign pop         = queue_nonempty && (!head_item.end_req || slot_free);
   assign load_result = pop && head_item.end_req;

   assign octet_next   = 12'(octet_value_ff) * 12'd10 + 12'(head_item.digit);
   assign port_next    = 20'(port_accum_ff) * 20'd10 + 20'(head_item.digit);
   assign address_full = {address_accum_ff[23:0], octet_value_ff[7:0]};

   // Next parse state.
   always_comb begin
      char_count_in    = char_count_ff;
      prefix_match_in  = prefix_match_ff;
      seen_colon_in    = seen_colon_ff;
      host_length_in   = host_length_ff;
      host_is_star_in  = host_is_star_ff;
      octet_value_in   = octet_value_ff;
      dot_count_in     = dot_count_ff;
      address_accum_in = address_accum_ff;
      host_bad_in      = host_bad_ff;
      port_accum_in    = port_accum_ff;
      port_bad_in      = port_bad_ff;
      port_digits_in   = port_digits_ff;

      if (pop) begin
         if (head_item.end_req) begin
            char_count_in    = '0;
            prefix_match_in  = 1'b1;
            seen_colon_in    = 1'b0;
            host_length_in   = '0;
            host_is_star_in  = 1'b0;
            octet_value_in   = '0;
            dot_count_in     = '0;
            address_accum_in = '0;
            host_bad_in      = 1'b0;
            port_accum_in    = '0;
            port_bad_in      = 1'b0;
            port_digits_in   = 1'b0;
         end else begin
            if (head_item.tag_miss) begin
               prefix_match_in = 1'b0;
            end
            if (char_count_ff < 3'(CHAR_COUNT_MAX)) begin
               char_count_in = char_count_ff + 3'd1;
            end

            if (seen_colon_ff || !head_item.is_colon) begin
               // Every character outside the colon split also feeds the port, so a bare
               // port needs no separate pass.
               if (head_item.is_digit) begin
                  port_accum_in  = (port_next > 20'(PORT_MAX)) ? 17'(PORT_SAT)
                                                               : port_next[16:0];
                  port_digits_in = 1'b1;
               end else begin
                  port_bad_in = 1'b1;
               end
            end else begin
               seen_colon_in  = 1'b1;
               port_accum_in  = '0;
               port_bad_in    = 1'b0;
               port_digits_in = 1'b0;
            end

            if (!seen_colon_ff && !head_item.is_colon) begin
               if (host_length_ff == '0) begin
                  host_is_star_in = head_item.is_star;
               end
               if (host_length_ff < 2'(HOST_LEN_MAX)) begin
                  host_length_in = host_length_ff + 2'd1;
               end
               if (head_item.is_digit) begin
                  if (octet_next > 12'(OCTET_MAX)) begin
                     host_bad_in    = 1'b1;
                     octet_value_in = 9'(OCTET_SAT);
                  end else begin
                     octet_value_in = octet_next[8:0];
                  end
               end else if (head_item.is_dot) begin
                  address_accum_in = address_full;
                  octet_value_in   = '0;
                  if (dot_count_ff < 3'(DOT_COUNT_MAX)) begin
                     dot_count_in = dot_count_ff + 3'd1;
                  end
               end else begin
                  host_bad_in = 1'b1;
               end
            end
         end
      end
   end

   // Result of the string closed by the terminator at the queue head.
   always_comb begin
      port_ok  = port_digits_ff && !port_bad_ff && (port_accum_ff != '0)
                 && (port_accum_ff <= 17'(PORT_MAX));
      err      = ERR_NONE;
      res_ip   = '0;
      res_port = '0;
      res_wild = 1'b0;
      if (char_count_ff == '0) begin
         err = ERR_EMPTY;
      end else if ((char_count_ff >= 3'(UNIX_REJECT_LEN)) && prefix_match_ff) begin
         err = ERR_UNIX;
      end else if (seen_colon_ff) begin
         if (!port_ok) begin
            err = ERR_BAD_PORT;
         end else if (host_length_ff == '0) begin
            err = ERR_NO_HOST;
         end else if ((host_length_ff == 2'd1) && host_is_star_ff) begin
            if (!listen_mode_ff) begin
               err = ERR_STAR_NO_LISTEN;
            end else begin
               res_wild = 1'b1;
               res_port = port_accum_ff[15:0];
            end
         end else if (host_bad_ff || (dot_count_ff != 3'(DOT_COUNT_REQ))
                      || (address_full == '1)) begin
            err = ERR_BAD_IP;
         end else begin
            res_ip   = address_full;
            res_port = port_accum_ff[15:0];
         end
      end else begin
         if (!listen_mode_ff) begin
            err = ERR_NEED_HOST;
         end else if (port_bad_ff || !port_digits_ff) begin
            err = ERR_NO_PORT;
         end else if (!port_ok) begin
            err = ERR_BAD_PORT;
         end else begin
            res_wild = 1'b1;
            res_port = port_accum_ff[15:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         listen_mode_ff   <= 1'b0;
         char_count_ff    <= '0;
         prefix_match_ff  <= 1'b1;
         seen_colon_ff    <= 1'b0;
         host_length_ff   <= '0;
         host_is_star_ff  <= 1'b0;
         octet_value_ff   <= '0;
         dot_count_ff     <= '0;
         address_accum_ff <= '0;
         host_bad_ff      <= 1'b0;
         port_accum_ff    <= '0;
         port_bad_ff      <= 1'b0;
         port_digits_ff   <= 1'b0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            listen_mode_ff <= csr_write_data;
         end
         char_count_ff    <= char_count_in;
         prefix_match_ff  <= prefix_match_in;
         seen_colon_ff    <= seen_colon_in;
         host_length_ff   <= host_length_in;
         host_is_star_ff  <= host_is_star_in;
         octet_value_ff   <= octet_value_in;
         dot_count_ff     <= dot_count_in;
         address_accum_ff <= address_accum_in;
         host_bad_ff      <= host_bad_in;
         port_accum_ff    <= port_accum_in;
         port_bad_ff      <= port_bad_in;
         port_digits_ff   <= port_digits_in;
         if (load_result) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load_result) begin
         rsp_ok_ff            <= (err == ERR_NONE);
         rsp_error_code_ff    <= err;
         rsp_ip_address_ff    <= res_ip;
         rsp_port_number_ff   <= res_port;
         rsp_wildcard_host_ff <= res_wild;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_ok            = rsp_ok_ff;
   assign rsp_error_code    = rsp_error_code_ff;
   assign rsp_ip_address    = rsp_ip_address_ff;
   assign rsp_port_number   = rsp_port_number_ff;
   assign rsp_wildcard_host = rsp_wildcard_host_ff;

   a_clear_after_end: assert property (@(posedge clock) disable iff (reset)
      load_result |=> char_count_ff == '0 && !seen_colon_ff && prefix_match_ff
                      && port_accum_ff == '0)
      else $error("parse state not cleared after terminator");

   a_error_zero_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_ok_ff |-> rsp_ip_address_ff == '0 && rsp_port_number_ff == '0
                                     && !rsp_wildcard_host_ff)
      else $error("error result carries nonzero fields");

   a_ok_matches_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> rsp_ok_ff == (rsp_error_code_ff == ERR_NONE))
      else $error("ok flag disagrees with error code");

endmodule

`default_nettype wire

// File: src/ipv4_endpoint_text_parser.sv
// Top level of the IPv4 endpoint text parser: front classifier, beat queue and back parser.
// Depends on ipep_pkg, ipep_front, ipep_queue and ipep_back.
//
// Usage: the string "host:port", a bare "port" or "*:port" arrives on the req_ channel
// one character per beat (req_ch); a beat with req_end_req high closes it. Only that
// terminator beat yields one beat on the rsp_ channel with ok, an error code, the
// address (first octet in the top byte), the port and a wildcard flag. Character beats
// produce nothing on rsp_.
// The csr_ port holds the single listen-mode bit, written whenever csr_write_enable is
// high; write it only while no string is in flight.
// Throughput is one beat per cycle while the queue has room: the front classifies a
// character in the cycle it is accepted and writes it into a four-entry queue, and the
// back consumes one queued beat per cycle, bar a waiting terminator, with a constant
// multiply-by-ten and flag updates. With the queue empty and no stall, the back pops an
// accepted terminator in the next cycle and raises rsp_valid at the following edge.
// When rsp_stall holds a result, the back keeps consuming character beats of the next
// string; only the next terminator waits, and req_stall rises once the queue is full.
// Reset (synchronous, active high) empties the queue, drops rsp_valid, clears the parse
// state and sets listen mode off.
`default_nettype none

module ipv4_endpoint_text_parser
   import ipep_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          csr_write_enable,
   input  wire logic          csr_write_data,
   input  wire logic          req_valid,
   output logic               req_stall,
   input  wire logic [7:0]    req_ch,
   input  wire logic          req_end_req,
   output logic               rsp_valid,
   input  wire logic          rsp_stall,
   output logic               rsp_ok,
   output logic [3:0]         rsp_error_code,
   output logic [31:0]        rsp_ip_address,
   output logic [15:0]        rsp_port_number,
   output logic               rsp_wildcard_host
);

   logic          push;
   ipep_item_type push_item;
   logic          queue_full;
   logic          queue_nonempty;
   ipep_item_type head_item;
   logic          pop;

   // The front classifies and counts prefix characters; other parse state lives in the back.
   ipep_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ch      (req_ch),
      .req_end_req (req_end_req),
      .queue_full  (queue_full),
      .req_stall   (req_stall),
      .push        (push),
      .push_item   (push_item)
   );

   ipep_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .pop       (pop),
      .full      (queue_full),
      .nonempty  (queue_nonempty),
      .head_item (head_item)
   );

   // The back owns the output register, so a stalled result never blocks character beats.
   ipep_back u_back (
      .clock             (clock),
      .reset             (reset),
      .csr_write_enable  (csr_write_enable),
      .csr_write_data    (csr_write_data),
      .queue_nonempty    (queue_nonempty),
      .head_item         (head_item),
      .pop               (pop),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_ok            (rsp_ok),
      .rsp_error_code    (rsp_error_code),
      .rsp_ip_address    (rsp_ip_address),
      .rsp_port_number   (rsp_port_number),
      .rsp_wildcard_host (rsp_wildcard_host)
   );

endmodule

`default_nettype wire

// File: dv/ipep_check_pkg.sv
// Scoreboard for the IPv4 endpoint text parser bench: a parse-state predictor, the queue of
// expected result beats and the field-by-field comparison against the rsp_ channel.
// Depends on ipep_pkg for character codes, limits and the error code enum.
package ipep_check_pkg;
   import ipep_pkg::*;

   typedef struct packed {
      logic [2:0]  char_count;
      logic        prefix_match;
      logic        seen_colon;
      logic [1:0]  host_length;
      logic        host_is_star;
      logic [8:0]  octet_value;
      logic [2:0]  dot_count;
      logic [31:0] address_accum;
      logic        host_bad;
      logic [16:0] port_accum;
      logic        port_bad;
      logic        port_digits;
   } parse_state_type;

   typedef struct packed {
      logic         ok;
      ipep_err_type code;
      logic [31:0]  ip;
      logic [15:0]  port;
      logic         wild;
   } endpoint_result_type;

   class endpoint_scoreboard;
      bit                  listen_mode;
      parse_state_type     parse;
      endpoint_result_type awaiting[$];
      int unsigned         failures;
      string               unix_prefix = "unix:";

      function new();
         clear_parse_state();
      endfunction

      function void clear_parse_state();
         parse = '0;
         parse.prefix_match = 1'b1;
      endfunction

      function void port_char(logic [7:0] c);
         logic [31:0] v;
         if (c >= CH_ZERO && c <= CH_NINE) begin
            v = parse.port_accum * 10 + (c - CH_ZERO);
            parse.port_accum = (v > PORT_MAX) ? 17'(PORT_SAT) : v[16:0];
            parse.port_digits = 1'b1;
         end else begin
            parse.port_bad = 1'b1;
         end
      endfunction

      function void host_char(logic [7:0] c);
         logic [31:0] v;
         if (parse.host_length == 0)
            parse.host_is_star = (c == CH_STAR);
         if (parse.host_length < HOST_LEN_MAX)
            parse.host_length++;
         if (c >= CH_ZERO && c <= CH_NINE) begin
            v = parse.octet_value * 10 + (c - CH_ZERO);
            if (v > OCTET_MAX) begin
               parse.host_bad = 1'b1;
               v = OCTET_SAT;
            end
            parse.octet_value = v[8:0];
         end else if (c == CH_DOT) begin
            parse.address_accum = {parse.address_accum[23:0], parse.octet_value[7:0]};
            parse.octet_value = '0;
            if (parse.dot_count < DOT_COUNT_MAX)
               parse.dot_count++;
         end else begin
            parse.host_bad = 1'b1;
         end
      endfunction

      function void take_char(logic [7:0] c);
         if (parse.char_count < UNIX_TAG_LEN && c != unix_prefix[parse.char_count])
            parse.prefix_match = 1'b0;
         if (parse.char_count < CHAR_COUNT_MAX)
            parse.char_count++;
         if (parse.seen_colon) begin
            port_char(c);
         end else if (c == CH_COLON) begin
            // The first colon splits host from port; the port restarts from scratch.
            parse.seen_colon = 1'b1;
            parse.port_accum = '0;
            parse.port_bad = 1'b0;
            parse.port_digits = 1'b0;
         end else begin
            host_char(c);
            port_char(c);
         end
      endfunction

      function endpoint_result_type close_string();
         endpoint_result_type r;
         logic                port_ok;
         logic [31:0]         joined;
         r = '0;
         r.code = ERR_NONE;
         port_ok = parse.port_digits && !parse.port_bad &&
                   parse.port_accum >= 1 && parse.port_accum <= PORT_MAX;
         joined = {parse.address_accum[23:0], parse.octet_value[7:0]};
         if (parse.char_count == 0) begin
            r.code = ERR_EMPTY;
         end else if (parse.char_count >= UNIX_REJECT_LEN && parse.prefix_match) begin
            r.code = ERR_UNIX;
         end else if (parse.seen_colon) begin
            if (!port_ok) begin
               r.code = ERR_BAD_PORT;
            end else if (parse.host_length == 0) begin
               r.code = ERR_NO_HOST;
            end else if (parse.host_length == 1 && parse.host_is_star) begin
               if (!listen_mode) begin
                  r.code = ERR_STAR_NO_LISTEN;
               end else begin
                  r.wild = 1'b1;
                  r.port = parse.port_accum[15:0];
               end
            end else if (parse.host_bad || parse.dot_count != DOT_COUNT_REQ ||
                         joined == 32'hFFFF_FFFF) begin
               r.code = ERR_BAD_IP;
            end else begin
               r.ip = joined;
               r.port = parse.port_accum[15:0];
            end
         end else begin
            if (!listen_mode)
               r.code = ERR_NEED_HOST;
            else if (parse.port_bad || !parse.port_digits)
               r.code = ERR_NO_PORT;
            else if (!port_ok)
               r.code = ERR_BAD_PORT;
            else begin
               r.wild = 1'b1;
               r.port = parse.port_accum[15:0];
            end
         end
         r.ok = (r.code == ERR_NONE);
         return r;
      endfunction

      // Called for every accepted input beat.
      function void note_beat(logic [7:0] ch, logic end_req);
         if (!end_req) begin
            take_char(ch);
         end else begin
            awaiting.push_back(close_string());
            clear_parse_state();
         end
      endfunction

      function void mismatch(longint stamp, string field, logic [31:0] want, logic [31:0] got);
         failures++;
         $display("%0d ns: %s expected 'h%0h, got 'h%0h", stamp, field, want, got);
      endfunction

      // Called for every accepted result beat.
      function void check_result(longint stamp, logic ok, logic [3:0] code, logic [31:0] ip,
                                 logic [15:0] port, logic wild);
         endpoint_result_type e;
         if (awaiting.size() == 0) begin
            failures++;
            $display("%0d ns: result beat with none expected, error_code %0d", stamp, code);
            return;
         end
         e = awaiting.pop_front();
         if (ok !== e.ok)
            mismatch(stamp, "ok", e.ok, ok);
         if (code !== e.code)
            mismatch(stamp, "error_code", e.code, code);
         if (ip !== e.ip)
            mismatch(stamp, "ip_address", e.ip, ip);
         if (port !== e.port)
            mismatch(stamp, "port_number", e.port, port);
         if (wild !== e.wild)
            mismatch(stamp, "wildcard_host", e.wild, wild);
      endfunction
   endclass

endpackage

// File: dv/ipv4_endpoint_text_parser_test.sv
// Top-level bench for ipv4_endpoint_text_parser: drives endpoint strings one character per
// beat, toggles listen mode between phases and checks every result beat.
// Depends on ipep_pkg, ipep_check_pkg and the parser RTL.
module ipv4_endpoint_text_parser_test;
   timeunit 1ns;
   timeprecision 1ps;

   import ipep_pkg::*;
   import ipep_check_pkg::*;

   // Number of random input beats to send after the directed strings.
   localparam int unsigned RANDOM_BEATS = 1280;
   // Random beats per listen-mode phase.
   localparam int unsigned PHASE_BEATS  = 300;
   // Settling time that drain() waits after the last expected result has come back.
   localparam int unsigned SETTLE_CYCLES = 4;
   // Cycles the receiver refuses results right after reset, so that the queue fills.
   localparam int unsigned HOLD_OFF_CYCLES = 120;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_write_enable = 1'b0;
   logic        csr_write_data = 1'b0;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [7:0]  req_ch = '0;
   logic        req_end_req = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b1;
   logic        rsp_ok;
   logic [3:0]  rsp_error_code;
   logic [31:0] rsp_ip_address;
   logic [15:0] rsp_port_number;
   logic        rsp_wildcard_host;

   endpoint_scoreboard board = new();

   // Characters of the string being built; the terminator is added when it is sent.
   logic [7:0]  text[$];
   int unsigned beats_sent = 0;
   // A dense string goes out back to back with no sender gaps.
   bit          dense = 1'b0;

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   ipv4_endpoint_text_parser uut (
      .clock             (clock),
      .reset             (reset),
      .csr_write_enable  (csr_write_enable),
      .csr_write_data    (csr_write_data),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_ch            (req_ch),
      .req_end_req       (req_end_req),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_ok            (rsp_ok),
      .rsp_error_code    (rsp_error_code),
      .rsp_ip_address    (rsp_ip_address),
      .rsp_port_number   (rsp_port_number),
      .rsp_wildcard_host (rsp_wildcard_host)
   );

   // Both handshakes are sampled here at the edge, before any of this edge's updates land.
   // The input beat is noted first; a result always trails its terminator through the queue
   // and the result register, so the order within this block never matters for correctness.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall)
            board.note_beat(req_ch, req_end_req);
         if (rsp_valid && !rsp_stall)
            board.check_result($time, rsp_ok, rsp_error_code, rsp_ip_address,
                               rsp_port_number, rsp_wildcard_host);
      end
   end

   // Idle length shared by both sides: mostly none or short, now and then a long one.
   function automatic int unsigned idle_cycles();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 60)
         return 0;
      else if (r < 88)
         return $urandom_range(1, 3);
      else if (r < 97)
         return $urandom_range(4, 12);
      else
         return $urandom_range(20, 40);
   endfunction

   // Receiver side. Right after reset it refuses results for a long stretch while the
   // sender keeps going, which fills the beat queue and pushes req_stall high. After that
   // it alternates runs of accepting (some of them long and quiet) with random stalls.
   initial begin
      int unsigned run;
      int unsigned len;
      while (reset)
         @(posedge clock);
      repeat (HOLD_OFF_CYCLES) @(posedge clock);
      forever begin
         rsp_stall <= 1'b0;
         run = ($urandom_range(0, 99) < 85) ? $urandom_range(1, 8) : $urandom_range(30, 80);
         repeat (run) @(posedge clock);
         len = idle_cycles();
         if (len > 0) begin
            rsp_stall <= 1'b1;
            repeat (len) @(posedge clock);
         end
      end
   end

   // Offers one beat and returns at the edge that accepts it. The caller's next drive
   // lands in that same step, so valid is never lowered and raised within one step.
   task automatic send_beat(logic [7:0] ch, logic end_req);
      int unsigned gap;
      gap = dense ? 0 : idle_cycles();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_ch      <= ch;
      req_end_req <= end_req;
      do
         @(posedge clock);
      while (req_stall);
      beats_sent++;
   endtask

   // Sends the built string followed by its terminator; the terminator carries a random
   // character, which the block must ignore.
   task automatic send_text();
      dense = ($urandom_range(0, 3) == 0);
      foreach (text[i])
         send_beat(text[i], 1'b0);
      send_beat(8'($urandom_range(0, 255)), 1'b1);
   endtask

   // Stops offering and waits until every expected result has come back, then lets the
   // pipeline settle so that a register write cannot overlap any work in flight. The first
   // edge lets the monitor note the last accepted terminator before the queue is checked.
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (board.awaiting.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_listen(bit mode);
      csr_write_enable <= 1'b1;
      csr_write_data   <= mode;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      board.listen_mode = mode;
   endtask

   task automatic put_str(string s);
      foreach (s[i])
         text.push_back(s[i]);
   endtask

   task automatic put_num(int unsigned v);
      put_str($sformatf("%0d", v));
   endtask

   task automatic send_str(string s);
      text.delete();
      put_str(s);
      send_text();
   endtask

   // Junk characters: half from the full byte range, half from the characters that matter.
   task automatic put_noise(int unsigned n);
      string alphabet;
      alphabet = "0123456789.:*u";
      repeat (n) begin
         if ($urandom_range(0, 1))
            text.push_back(8'($urandom_range(0, 255)));
         else
            text.push_back(alphabet[$urandom_range(0, alphabet.len() - 1)]);
      end
   endtask

   // One octet: mostly legal, with empty octets, leading zeros and overflow mixed in.
   task automatic put_octet();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 5)
         return;
      if (r < 10)
         put_str("0");
      if (r < 80)
         put_num($urandom_range(0, OCTET_MAX));
      else if (r < 88)
         put_num($urandom_range(OCTET_SAT, 999));
      else if (r < 93)
         put_num(OCTET_MAX);
      else
         put_num($urandom_range(0, 9));
   endtask

   // Dotted host, usually four octets; sometimes the broadcast address or a wrong count.
   task automatic put_host();
      int unsigned r;
      int unsigned n;
      r = $urandom_range(0, 99);
      n = 4;
      if (r < 3) begin
         put_str("255.255.255.255");
         return;
      end
      if (r < 7)
         n = 3;
      else if (r < 11)
         n = 5;
      for (int unsigned i = 0; i < n; i++) begin
         if (i != 0)
            put_str(".");
         put_octet();
      end
   endtask

   // Port text: mostly legal, with empty ports, zero and values past the top.
   task automatic put_port();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 5)
         return;
      if (r < 12)
         put_str("0");
      if (r < 70)
         put_num($urandom_range(1, PORT_MAX));
      else if (r < 80)
         put_num($urandom_range(1, 999));
      else begin
         case ($urandom_range(0, 5))
            0: put_num(0);
            1: put_num(1);
            2: put_num(PORT_MAX);
            3: put_num(PORT_SAT);
            4: put_num(99999);
            default: put_num(1234567);
         endcase
      end
   endtask

   // Most strings are well formed with random content so the parse reaches its later
   // checks; the rest are star hosts, bare ports, unix prefixes, damaged strings and noise.
   task automatic make_random_text();
      int unsigned r;
      int unsigned pos;
      text.delete();
      r = $urandom_range(0, 99);
      if (r < 45) begin
         put_host();
         put_str(":");
         put_port();
      end else if (r < 55) begin
         put_str("*");
         if ($urandom_range(0, 7) == 0)
            put_noise(1);
         put_str(":");
         put_port();
      end else if (r < 67) begin
         put_port();
         if ($urandom_range(0, 5) == 0)
            put_noise(1);
      end else if (r < 72) begin
         if ($urandom_range(0, 3) == 0)
            put_str("unix");
         else
            put_str("unix:");
         put_noise($urandom_range(0, 3));
      end else if (r < 86) begin
         put_host();
         put_str(":");
         put_port();
         pos = $urandom_range(0, text.size() - 1);
         case ($urandom_range(0, 2))
            0: text[pos] = 8'($urandom_range(0, 255));
            1: text.insert(pos, CH_COLON);
            default: text.delete(pos);
         endcase
      end else begin
         put_noise($urandom_range(0, 9));
      end
   endtask

   // Last-resort stop in case the handshakes hang.
   initial begin
      #(10_000_000);
      $display("FAIL ipv4_endpoint_text_parser");
      $finish;
   end

   initial begin
      bit          mode;
      int unsigned goal;
      int unsigned phase_end;

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Directed strings without listen mode: empty, unix prefix cases, a plain endpoint,
      // the star host refused, a bare port refused, missing host, empty and out-of-range
      // ports, the broadcast address, empty octets, an octet overflow, too few dots and
      // a second colon inside the port.
      write_listen(1'b0);
      send_str("");
      send_str("unix:");
      send_str("unix:x");
      send_str("1.2.3.4:80");
      send_str("*:1");
      send_str("80");
      send_str(":5");
      send_str("1.2.3.4:");
      send_str("9.9.9.9:0");
      send_str("0.0.0.0:65535");
      send_str("10.0.0.1:65536");
      send_str("255.255.255.255:1");
      send_str("1..2.3:7");
      send_str("256.1.1.1:1");
      send_str("1.2.3:1");
      send_str("a.b:1:2");
      drain();

      // Directed strings in listen mode: star host, bare ports at and past the limits,
      // a bare port with a non-digit, a two-character host starting with a star.
      write_listen(1'b1);
      send_str("*:65535");
      send_str("443");
      send_str("65536");
      send_str("0");
      send_str("8a");
      send_str("unix");
      send_str("*x:1");
      send_str("");
      drain();

      // Random phases, flipping listen mode each time.
      goal = beats_sent + RANDOM_BEATS;
      mode = 1'b0;
      while (beats_sent < goal) begin
         write_listen(mode);
         phase_end = beats_sent + PHASE_BEATS;
         while (beats_sent < phase_end && beats_sent < goal) begin
            make_random_text();
            send_text();
         end
         drain();
         mode = !mode;
      end

      if (board.awaiting.size() != 0) begin
         board.failures++;
         $display("%0d ns: %0d expected results never arrived", $time, board.awaiting.size());
      end
      if (board.failures == 0)
         $display("PASS ipv4_endpoint_text_parser");
      else
         $display("FAIL ipv4_endpoint_text_parser");
      $finish;
   end

endmodule
